// ===== sv/swr_pkg.sv =====
`timescale 1ns / 1ps

package swr_pkg;

  // Field widths fixed by the header format
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int ID_W     = 16;
  localparam int OFF_W    = 32;
  localparam int PLEN_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Largest payload a segment may carry; longer lengths are clipped
  localparam logic [PLEN_W-1:0] MAX_PAYLOAD = PLEN_W'(512);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PEER_BOUND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEER_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PEER_PORT    = 2'd2;

  // Result verdicts
  typedef enum logic [2:0] {
    VERDICT_WRONG_PEER = 3'd0,
    VERDICT_ACK_FWD    = 3'd1,
    VERDICT_INVALID    = 3'd2,
    VERDICT_IGNORED    = 3'd3,
    VERDICT_APPENDED   = 3'd4,
    VERDICT_DUPLICATE  = 3'd5
  } verdict_t;

  // Classification made by the front end, independent of receiver state
  typedef enum logic [1:0] {
    CLS_WRONG_PEER = 2'd0,
    CLS_ACK        = 2'd1,
    CLS_INVALID    = 2'd2,
    CLS_DATA       = 2'd3
  } cls_t;

  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic [PORT_W-1:0] source_port;
    logic              is_ack;
    logic [ID_W-1:0]   message_id;
    logic [OFF_W-1:0]  byte_offset;
    logic [OFF_W-1:0]  total_bytes;
    logic [PLEN_W-1:0] payload_bytes;
  } in_beat_t;

  typedef struct packed {
    verdict_t         verdict;
    logic             ack_due;
    logic             ack_to_source;
    logic [OFF_W-1:0] append_offset;
    logic             message_done;
    logic [OFF_W-1:0] gathered_bytes;
  } out_beat_t;

  // Classified header passed from front to back through the queue
  typedef struct packed {
    cls_t              cls;
    logic [ID_W-1:0]   message_id;
    logic [OFF_W-1:0]  byte_offset;
    logic [OFF_W-1:0]  end_offset;   // low bits of offset + clipped length
    logic              completes;    // total <= offset + length, no wrap
    logic [PLEN_W-1:0] plen;         // clipped payload length
  } cmd_t;

  typedef struct packed {
    logic                 bound;
    logic [ADDR_W-1:0]    address;
    logic [PORT_W-1:0]    port;
  } peer_cfg_t;

endpackage

// ===== sv/stop_and_wait_reassembly_receiver_core.sv =====
`timescale 1ns / 1ps

// Stop-and-wait reassembly receiver: takes one datagram header per beat and
// returns exactly one result beat per header, in order, giving the verdict,
// whether and where to send an acknowledgment, where the payload is appended
// and whether the message completes. Sustained rate is one header per cycle
// unless a stall holds it. The front end classifies headers against the
// peer configuration and feeds a two-entry queue; the back end pops it,
// updating the receiver state and result register once per cycle, so a
// stalled output holds at most two further headers before in_stall rises.
// The user must write peer registers through cfg_wr_en / cfg_index /
// cfg_wdata only while no header is in flight; the block does not enforce it.
// Index 0 is peer_bound, 1 peer_address, 2 peer_port, others are ignored.
module stop_and_wait_reassembly_receiver_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  swr_pkg::in_beat_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output swr_pkg::out_beat_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [swr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  swr_pkg::peer_cfg_t peer_r;
  logic               push, pop, q_full, q_valid;
  swr_pkg::cmd_t      push_cmd, q_head;

  // Peer configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        swr_pkg::REG_PEER_BOUND:   peer_r.bound   <= cfg_wdata[0];
        swr_pkg::REG_PEER_ADDRESS: peer_r.address <= cfg_wdata[swr_pkg::ADDR_W-1:0];
        swr_pkg::REG_PEER_PORT:    peer_r.port    <= cfg_wdata[swr_pkg::PORT_W-1:0];
        default: ;
      endcase
    end
  end

  swr_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .peer     (peer_r),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  swr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .q_head   (q_head)
  );

  swr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .peer_bound (peer_r.bound),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== sv/swr_front.sv =====
`timescale 1ns / 1ps

module swr_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  swr_pkg::in_beat_t in_data,
  input  swr_pkg::peer_cfg_t peer,
  input  logic              q_full,
  output logic              push,
  output swr_pkg::cmd_t     push_cmd
);

  logic [swr_pkg::PLEN_W-1:0] plen;
  logic [swr_pkg::OFF_W:0]    end_wide;
  logic                       mismatch;
  logic                       first_seg;

  // Handshake: a beat is taken whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

  // Clip payload length, form the segment end without wrap
  always_comb begin
    plen = (in_data.payload_bytes > swr_pkg::MAX_PAYLOAD) ?
           swr_pkg::MAX_PAYLOAD : in_data.payload_bytes;
    end_wide = {1'b0, in_data.byte_offset} +
               {{(swr_pkg::OFF_W + 1 - swr_pkg::PLEN_W){1'b0}}, plen};
  end

  // State-independent classification
  always_comb begin
    mismatch  = peer.bound && (in_data.source_address != peer.address ||
                               in_data.source_port != peer.port);
    first_seg = !peer.bound && (in_data.byte_offset == '0) &&
                ({{(swr_pkg::OFF_W - swr_pkg::PLEN_W){1'b0}}, plen} < in_data.total_bytes);

    push_cmd.message_id  = in_data.message_id;
    push_cmd.byte_offset = in_data.byte_offset;
    push_cmd.end_offset  = end_wide[swr_pkg::OFF_W-1:0];
    push_cmd.completes   = ({1'b0, in_data.total_bytes} <= end_wide);
    push_cmd.plen        = plen;

    if (mismatch) begin
      push_cmd.cls = swr_pkg::CLS_WRONG_PEER;
    end else if (in_data.is_ack) begin
      push_cmd.cls = swr_pkg::CLS_ACK;
    end else if (first_seg) begin
      push_cmd.cls = swr_pkg::CLS_INVALID;
    end else begin
      push_cmd.cls = swr_pkg::CLS_DATA;
    end
  end

endmodule

// ===== sv/swr_queue.sv =====
`timescale 1ns / 1ps

module swr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  swr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          q_full,
  output logic          q_valid,
  output swr_pkg::cmd_t q_head
);

  swr_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign q_full  = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_head  = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_full || pop) && count_r != 2'd3)
    else $error("queue overrun");
`endif

endmodule

// ===== sv/swr_back.sv =====
`timescale 1ns / 1ps

module swr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               peer_bound,
  input  logic               q_valid,
  input  swr_pkg::cmd_t      q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output swr_pkg::out_beat_t out_data
);

  typedef enum logic {
    ST_IDLE,
    ST_RECV
  } state_t;

  state_t                   state_r, state_nxt;
  logic [swr_pkg::ID_W-1:0] cur_id_r, cur_id_nxt;
  logic [swr_pkg::OFF_W-1:0] last_off_r, last_off_nxt;
  logic [swr_pkg::OFF_W-1:0] next_off_r, next_off_nxt;
  logic [swr_pkg::OFF_W-1:0] gathered_r, gathered_nxt;
  logic                     out_valid_r, out_valid_nxt;
  swr_pkg::out_beat_t       out_data_r, res;
  logic [swr_pkg::OFF_W-1:0] plen_ext;
  logic [swr_pkg::OFF_W-1:0] gathered_sum;

  // Take the next command whenever the output register is free or draining
  assign pop       = q_valid & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Receiver decision for the head command
  always_comb begin
    plen_ext     = {{(swr_pkg::OFF_W - swr_pkg::PLEN_W){1'b0}}, q_head.plen};
    gathered_sum = gathered_r + plen_ext;

    state_nxt    = state_r;
    cur_id_nxt   = cur_id_r;
    last_off_nxt = last_off_r;
    next_off_nxt = next_off_r;
    gathered_nxt = gathered_r;

    res.verdict       = swr_pkg::VERDICT_IGNORED;
    res.ack_due       = 1'b0;
    res.ack_to_source = 1'b0;
    res.append_offset = '0;
    res.message_done  = 1'b0;

    unique case (q_head.cls)
      swr_pkg::CLS_WRONG_PEER: res.verdict = swr_pkg::VERDICT_WRONG_PEER;
      swr_pkg::CLS_ACK:        res.verdict = swr_pkg::VERDICT_ACK_FWD;
      swr_pkg::CLS_INVALID:    res.verdict = swr_pkg::VERDICT_INVALID;
      default: begin
        if (state_r == ST_IDLE) begin
          // only offset zero opens a message
          if (q_head.byte_offset == '0) begin
            cur_id_nxt        = q_head.message_id;
            last_off_nxt      = '0;
            next_off_nxt      = plen_ext;
            gathered_nxt      = plen_ext;
            res.verdict       = swr_pkg::VERDICT_APPENDED;
            res.ack_due       = 1'b1;
            res.ack_to_source = 1'b1;
            if (q_head.completes) begin
              res.message_done = 1'b1;
            end else begin
              state_nxt = ST_RECV;
            end
          end
        end else if (q_head.message_id == cur_id_r) begin
          if (q_head.byte_offset == next_off_r) begin
            // in-order segment
            last_off_nxt      = q_head.byte_offset;
            next_off_nxt      = q_head.end_offset;
            res.append_offset = gathered_r;
            gathered_nxt      = gathered_sum;
            res.verdict       = swr_pkg::VERDICT_APPENDED;
            res.ack_due       = peer_bound;
            if (q_head.completes) begin
              res.message_done = 1'b1;
              state_nxt        = ST_IDLE;
            end
          end else if (q_head.byte_offset == last_off_r) begin
            res.verdict = swr_pkg::VERDICT_DUPLICATE;
            res.ack_due = peer_bound;
          end
        end
      end
    endcase

    res.gathered_bytes = gathered_nxt;
    if (res.message_done) begin
      gathered_nxt = '0;
    end

    out_valid_nxt = pop ? 1'b1 : (out_valid_r & out_stall);
  end

  // Receiver state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_id_r    <= '0;
      last_off_r  <= '0;
      next_off_r  <= '0;
      gathered_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        state_r    <= state_nxt;
        cur_id_r   <= cur_id_nxt;
        last_off_r <= last_off_nxt;
        next_off_r <= next_off_nxt;
        gathered_r <= gathered_nxt;
        out_data_r <= res;
      end
    end
  end

`ifndef SYNTH
  a_done_is_append: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.message_done |->
      out_data_r.verdict == swr_pkg::VERDICT_APPENDED)
    else $error("completion without append");
  a_ack_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.ack_due |-> !out_data_r.ack_to_source)
    else $error("ack destination set without ack");
  a_done_resets: assert property (@(posedge clk) disable iff (!rst_n)
    pop && res.message_done |=> state_r == ST_IDLE && gathered_r == '0)
    else $error("receiver not back to idle after completion");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !pop)
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_WAIT      = 12;
  localparam int CHOKE_CYCLES  = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 112;
  localparam int ITEM_TARGET   = 1150;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 10;

  // index 3 has no register behind it; writes there must be ignored
  localparam logic [swr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  swr_pkg::in_beat_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  swr_pkg::out_beat_t             out_data;
  logic                           cfg_wr_en = 1'b0;
  logic [swr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [swr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  stop_and_wait_reassembly_receiver_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Peer configuration as the receiver should see it
  logic        peer_on = 1'b0;
  logic [31:0] peer_addr = '0;
  logic [15:0] peer_port = '0;

  // Reassembly state tracked alongside the block
  logic        rx_active = 1'b0;
  logic [15:0] rx_id = '0;
  logic [31:0] rx_last_off = '0;
  logic [31:0] rx_next_off = '0;
  logic [31:0] rx_gathered = '0;

  swr_pkg::in_beat_t  pending_hdrs[$];
  swr_pkg::out_beat_t expected_results[$];

  int          items_queued = 0;
  int          results_seen = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          rx_wait = 0;
  int          choke_left = 0;
  int          choke_ask = 0;
  int          choke_seen = 0;
  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;

  // Decision for one header; updates the tracked reassembly state
  task automatic reassemble_header(input swr_pkg::in_beat_t h,
                                   output swr_pkg::out_beat_t r);
    logic [swr_pkg::PLEN_W-1:0] plen;
    logic [32:0]                seg_end;
    logic                       completes;
    r = '0;
    r.verdict = swr_pkg::VERDICT_IGNORED;
    plen = (h.payload_bytes > swr_pkg::MAX_PAYLOAD) ? swr_pkg::MAX_PAYLOAD : h.payload_bytes;
    seg_end = 33'(h.byte_offset) + 33'(plen);
    completes = 33'(h.total_bytes) <= seg_end;
    if (peer_on && (h.source_address != peer_addr || h.source_port != peer_port)) begin
      r.verdict = swr_pkg::VERDICT_WRONG_PEER;
    end else if (h.is_ack) begin
      r.verdict = swr_pkg::VERDICT_ACK_FWD;
    end else if (!peer_on && h.byte_offset == 0 && 32'(plen) < h.total_bytes) begin
      r.verdict = swr_pkg::VERDICT_INVALID;
    end else if (!rx_active) begin
      // only a segment at offset zero opens a message; ack goes back to its source
      if (h.byte_offset == 0) begin
        rx_id = h.message_id;
        rx_last_off = '0;
        rx_next_off = 32'(plen);
        rx_gathered = 32'(plen);
        r.verdict = swr_pkg::VERDICT_APPENDED;
        r.ack_due = 1'b1;
        r.ack_to_source = 1'b1;
        if (completes) r.message_done = 1'b1;
        else rx_active = 1'b1;
      end
    end else if (h.message_id == rx_id) begin
      // in-order wins over duplicate when an empty segment made them equal
      if (h.byte_offset == rx_next_off) begin
        rx_last_off = h.byte_offset;
        rx_next_off = seg_end[31:0];
        r.append_offset = rx_gathered;
        rx_gathered = rx_gathered + 32'(plen);
        r.verdict = swr_pkg::VERDICT_APPENDED;
        r.ack_due = peer_on;
        if (completes) begin
          r.message_done = 1'b1;
          rx_active = 1'b0;
        end
      end else if (h.byte_offset == rx_last_off) begin
        r.verdict = swr_pkg::VERDICT_DUPLICATE;
        r.ack_due = peer_on;
      end
    end
    r.gathered_bytes = rx_gathered;
    if (r.message_done) rx_gathered = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("mismatch on %s at result %0d: expected 0x%0h, got 0x%0h",
               what, results_seen, want, got);
    end
  endtask

  task automatic check_result(input swr_pkg::out_beat_t got);
    swr_pkg::out_beat_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch("result with none pending", 64'd0, 64'(got.verdict));
    end else begin
      want = expected_results.pop_front();
      if (got.verdict !== want.verdict)
        report_mismatch("verdict", 64'(want.verdict), 64'(got.verdict));
      if (got.ack_due !== want.ack_due)
        report_mismatch("ack_due", 64'(want.ack_due), 64'(got.ack_due));
      if (got.ack_to_source !== want.ack_to_source)
        report_mismatch("ack_to_source", 64'(want.ack_to_source), 64'(got.ack_to_source));
      if (got.append_offset !== want.append_offset)
        report_mismatch("append_offset", 64'(want.append_offset), 64'(got.append_offset));
      if (got.message_done !== want.message_done)
        report_mismatch("message_done", 64'(want.message_done), 64'(got.message_done));
      if (got.gathered_bytes !== want.gathered_bytes)
        report_mismatch("gathered_bytes", 64'(want.gathered_bytes), 64'(got.gathered_bytes));
    end
  endtask

  function automatic swr_pkg::in_beat_t mk_hdr(input logic [31:0] addr,
                                               input logic [15:0] port,
                                               input logic ack, input logic [15:0] id,
                                               input logic [31:0] off,
                                               input logic [31:0] total,
                                               input logic [9:0] plen);
    swr_pkg::in_beat_t h;
    h.source_address = addr;
    h.source_port    = port;
    h.is_ack         = ack;
    h.message_id     = id;
    h.byte_offset    = off;
    h.total_bytes    = total;
    h.payload_bytes  = plen;
    return h;
  endfunction

  task automatic send_hdr(input swr_pkg::in_beat_t h);
    pending_hdrs = {pending_hdrs, h};
    items_queued++;
  endtask

  // Stray beats that must not disturb the message in progress
  task automatic queue_noise(input logic [15:0] live_id, input logic [31:0] next_off);
    logic [31:0] a;
    logic [15:0] p;
    a = peer_on ? peer_addr : $urandom;
    p = peer_on ? peer_port : 16'($urandom);
    case ($urandom_range(0, 3))
      0: send_hdr(mk_hdr(a, p, 1'b1, 16'($urandom), $urandom, $urandom, 10'($urandom)));
      1: begin
        if (peer_on) begin
          if ($urandom_range(0, 1)) a = a ^ ($urandom | 32'd1);
          else p = p ^ (16'($urandom) | 16'd1);
          send_hdr(mk_hdr(a, p, 1'($urandom), 16'($urandom), $urandom, $urandom,
                          10'($urandom)));
        end else begin
          send_hdr(mk_hdr(a, p, 1'b0, live_id ^ (16'($urandom) | 16'd1),
                          $urandom | 32'd1, $urandom, 10'($urandom)));
        end
      end
      2: send_hdr(mk_hdr(a, p, 1'b0, live_id ^ (16'($urandom) | 16'd1),
                         $urandom | 32'd1, $urandom, 10'($urandom)));
      default: send_hdr(mk_hdr(a, p, 1'b0, live_id,
                               next_off + 32'($urandom_range(1, 4096)),
                               $urandom, 10'($urandom)));
    endcase
  endtask

  // One message cut into segments, with repeats and stray beats mixed in
  task automatic queue_message();
    logic [31:0]       src_a;
    logic [15:0]       src_p;
    logic [15:0]       id;
    logic [31:0]       total;
    logic [31:0]       off;
    logic [9:0]        plen;
    swr_pkg::in_beat_t seg;
    int                segs;
    src_a = peer_on ? peer_addr : $urandom;
    src_p = peer_on ? peer_port : 16'($urandom);
    id = 16'($urandom);
    case ($urandom_range(0, 9))
      0:       total = '0;
      1, 2:    total = $urandom_range(1, 512);
      default: total = peer_on ? $urandom_range(1, 2000) : $urandom_range(0, 600);
    endcase
    off = '0;
    segs = 0;
    do begin
      case ($urandom_range(0, 9))
        0:       plen = '0;
        1:       plen = 10'($urandom_range(513, 1023));
        2, 3:    plen = (total - off > 32'd512) ? 10'd512 : 10'(total - off);
        default: plen = 10'($urandom_range(1, 512));
      endcase
      seg = mk_hdr(src_a, src_p, 1'b0, id, off, total, plen);
      send_hdr(seg);
      if ($urandom_range(0, 5) == 0) send_hdr(seg);
      off = off + ((plen > swr_pkg::MAX_PAYLOAD) ? 32'(swr_pkg::MAX_PAYLOAD) : 32'(plen));
      if ($urandom_range(0, 3) == 0) queue_noise(id, off);
      segs++;
    end while (off < total && segs < 64);
  endtask

  task automatic write_reg(input logic [swr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      swr_pkg::REG_PEER_BOUND:   peer_on = val[0];
      swr_pkg::REG_PEER_ADDRESS: peer_addr = val;
      swr_pkg::REG_PEER_PORT:    peer_port = val[15:0];
      default: ;
    endcase
  endtask

  // Hold until every beat is in and every result is back, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_hdrs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Header driver; the expectation is formed at the edge that takes the beat
  always @(posedge clk) begin
    swr_pkg::out_beat_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        reassemble_header(in_data, r);
        expected_results = {expected_results, r};
      end
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_hdrs.size() != 0) begin
        in_data <= pending_hdrs.pop_front();
        in_valid <= 1'b1;
        send_gap = send_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started on request
  always @(posedge clk) begin
    if (!rst_n) begin
      choke_left <= 0;
    end else if (choke_left != 0) begin
      choke_left <= choke_left - 1;
    end else if (choke_seen != choke_ask) begin
      choke_seen = choke_ask;
      choke_left <= CHOKE_CYCLES;
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
        rx_wait = recv_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0) || (choke_left != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // No peer bound: acks, idle offsets, first of several segments, single segments
    send_hdr(mk_hdr(32'h0A000001, 16'd5000, 1'b1, 16'd1, 32'd0, 32'd0, 10'd0));
    send_hdr(mk_hdr(32'h0A000001, 16'd5000, 1'b0, 16'd1, 32'd100, 32'd300, 10'd100));
    send_hdr(mk_hdr(32'h0A000001, 16'd5000, 1'b0, 16'd2, 32'd0, 32'd1000, 10'd100));
    send_hdr(mk_hdr(32'h0A000002, 16'd5001, 1'b0, 16'd3, 32'd0, 32'd200, 10'd200));
    send_hdr(mk_hdr(32'h0A000003, 16'd5002, 1'b0, 16'd4, 32'd0, 32'd512, 10'd1023));
    send_hdr(mk_hdr(32'h00000000, 16'd0, 1'b0, 16'd0, 32'd0, 32'd0, 10'd0));
    send_hdr(mk_hdr('1, '1, 1'b0, '1, '1, '1, '1));
    wait_drained();

    // Bound peer: wrong source, duplicates, empty segments, gaps, a clipped segment
    write_reg(swr_pkg::REG_PEER_BOUND, 32'd1);
    write_reg(swr_pkg::REG_PEER_ADDRESS, 32'hC0A80001);
    write_reg(swr_pkg::REG_PEER_PORT, 32'h1F90);
    @(negedge clk);
    send_hdr(mk_hdr(32'hC0A80000, 16'h1F90, 1'b0, 16'd7, 32'd0, 32'd1000, 10'd400));
    send_hdr(mk_hdr(32'hC0A80001, 16'h9F90, 1'b1, 16'd7, 32'd0, 32'd0, 10'd0));
    send_hdr(mk_hdr(32'hC0A80001, 16'h1F90, 1'b0, 16'd7, 32'd0, 32'd1000, 10'd400));
    send_hdr(mk_hdr(32'hC0A80001, 16'h1F90, 1'b0, 16'd8, 32'd400, 32'd1000, 10'd100));
    send_hdr(mk_hdr(32'hC0A80001, 16'h1F90, 1'b0, 16'd7, 32'd0, 32'd1000, 10'd400));
    send_hdr(mk_hdr(32'hC0A80001, 16'h1F90, 1'b0, 16'd7, 32'd400, 32'd1000, 10'd0));
    send_hdr(mk_hdr(32'hC0A80001, 16'h1F90, 1'b0, 16'd7, 32'd400, 32'd1000, 10'd0));
    send_hdr(mk_hdr(32'hC0A80001, 16'h1F90, 1'b0, 16'd7, 32'd900, 32'd1000, 10'd100));
    send_hdr(mk_hdr(32'hC0A80001, 16'h1F90, 1'b0, 16'd7, 32'd400, 32'd1000, 10'd600));
    send_hdr(mk_hdr(32'hC0A80001, 16'h1F90, 1'b1, 16'd7, 32'd1000, 32'd1000, 10'd0));
    send_hdr(mk_hdr(32'hC0A80001, 16'h1F90, 1'b0, 16'd9, 32'd0, 32'd5000, 10'd100));
    wait_drained();

    // Unbound while a message is still open: acks have nowhere to go
    write_reg(swr_pkg::REG_PEER_BOUND, 32'd0);
    @(negedge clk);
    send_hdr(mk_hdr(32'h01020304, 16'd80, 1'b0, 16'd9, 32'd100, 32'd5000, 10'd100));
    send_hdr(mk_hdr(32'h01020304, 16'd80, 1'b0, 16'd9, 32'd100, 32'd5000, 10'd100));
    send_hdr(mk_hdr(32'h01020304, 16'd80, 1'b1, 16'd9, 32'd0, 32'd0, 10'd0));
    send_hdr(mk_hdr(32'h01020304, 16'd80, 1'b0, 16'd9, 32'd0, 32'd100, 10'd10));
    send_hdr(mk_hdr(32'h01020304, 16'd80, 1'b0, 16'd9, 32'd200, 32'd712, 10'd512));

    // Random phases, each under its own peer setting
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      wait_drained();
      case (phase % 4)
        0: begin
          write_reg(swr_pkg::REG_PEER_BOUND, 32'd1);
          write_reg(swr_pkg::REG_PEER_ADDRESS, '1);
          write_reg(swr_pkg::REG_PEER_PORT, 32'h0000FFFF);
        end
        1: begin
          write_reg(swr_pkg::REG_PEER_BOUND, 32'd1);
          write_reg(swr_pkg::REG_PEER_ADDRESS, '0);
          write_reg(swr_pkg::REG_PEER_PORT, '0);
        end
        2: begin
          write_reg(swr_pkg::REG_PEER_BOUND, $urandom | 32'd1);
          write_reg(swr_pkg::REG_PEER_ADDRESS, $urandom);
          write_reg(swr_pkg::REG_PEER_PORT, $urandom);
        end
        default: begin
          write_reg(swr_pkg::REG_PEER_BOUND, $urandom & 32'hFFFFFFFE);
          write_reg(swr_pkg::REG_PEER_ADDRESS, $urandom);
          write_reg(swr_pkg::REG_PEER_PORT, $urandom);
        end
      endcase
      write_reg(REG_UNUSED, $urandom);
      @(negedge clk);
      send_idle_on = (phase % 3 != 1);
      recv_idle_on = (phase % 5 != 2);
      // first phase: sender keeps offering while the receiver holds off
      if (phase == 0) begin
        send_idle_on = 1'b0;
        choke_ask++;
      end
      while (pending_hdrs.size() < PHASE_ITEMS) queue_message();
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== stop_and_wait_reassembly_receiver_core.f =====
sv/swr_pkg.sv
sv/swr_front.sv
sv/swr_queue.sv
sv/swr_back.sv
sv/stop_and_wait_reassembly_receiver_core.sv
dv/testbench.sv
